// ----- rtl/signed_number_to_digit_writes_core_defines.svh -----
// Assertion macros used by the checker of the digit write core.
`ifndef SIGNED_NUMBER_TO_DIGIT_WRITES_CORE_DEFINES_SVH
`define SIGNED_NUMBER_TO_DIGIT_WRITES_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define S2DW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("digit write core check failed");

// Next-cycle implication, disabled during reset
`define S2DW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("digit write core check failed");

`endif

// ----- rtl/s2dw_pkg.sv -----
// Shared types and constants of the signed number to digit write core.
`timescale 1ns / 1ps

package s2dw_pkg;

   localparam int VALUE_W     = 16;
   localparam int ADDR_W      = 3;
   localparam int DATA_W      = 8;
   localparam int RSP_TDATA_W = 16;
   localparam int MAG_W       = 14;
   localparam int REM_W       = 10;
   localparam int DIGIT_W     = 4;
   localparam int STEP_W      = 2;

   // Display range
   localparam logic signed [VALUE_W-1:0] UPPER_LIMIT = 16'sd9999;
   localparam logic signed [VALUE_W-1:0] LOWER_LIMIT = -16'sd999;

   // Minus sign code in BCD decode mode
   localparam logic [DATA_W-1:0] SIGN_CODE = 8'd106;

   // Digit register addresses
   localparam logic [ADDR_W-1:0] ADDR_UNITS    = 3'd1;
   localparam logic [ADDR_W-1:0] ADDR_TENS     = 3'd2;
   localparam logic [ADDR_W-1:0] ADDR_HUNDREDS = 3'd3;
   localparam logic [ADDR_W-1:0] ADDR_TOP      = 3'd4;

   // Back end step codes
   localparam logic [STEP_W-1:0] STEP_TOP      = 2'd0;
   localparam logic [STEP_W-1:0] STEP_UNITS    = 2'd1;
   localparam logic [STEP_W-1:0] STEP_TENS     = 2'd2;
   localparam logic [STEP_W-1:0] STEP_HUNDREDS = 2'd3;

   // Reciprocals: x/1000 = (x*16778)>>24 exact for x <= 9999,
   // x/10 = (x*205)>>11 exact for x < 1029
   localparam int          RECIP1000_W = 15;
   localparam int          RECIP1000_SH = 24;
   localparam logic [RECIP1000_W-1:0] RECIP1000 = 15'd16778;
   localparam int          RECIP10_W = 8;
   localparam int          RECIP10_SH = 11;
   localparam logic [RECIP10_W-1:0] RECIP10 = 8'd205;

   // Two-entry queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // Classified request: sign flag, thousands digit, value below thousands
   typedef struct packed {
      logic               neg;
      logic [DIGIT_W-1:0] thou;
      logic [REM_W-1:0]   rem;
   } s2dw_entry_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } s2dw_qstat_type;

endpackage

// ----- rtl/s2dw_queue.sv -----
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps

module s2dw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  s2dw_pkg::s2dw_entry_type push_entry,
   input  logic                     pop,
   output s2dw_pkg::s2dw_entry_type head,
   output s2dw_pkg::s2dw_qstat_type stat
);

   s2dw_pkg::s2dw_entry_type mem_ff [s2dw_pkg::QUEUE_DEPTH];
   logic [s2dw_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [s2dw_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [s2dw_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             do_push, do_pop;

   assign stat.full  = (count_ff == s2dw_pkg::QUEUE_CNT_W'(s2dw_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- rtl/s2dw_front.sv -----
// Front end: accepts numbers, drops out-of-range ones, splits off the top digit.
`timescale 1ns / 1ps

module s2dw_front (
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic signed [s2dw_pkg::VALUE_W-1:0]  req_value,
   input  s2dw_pkg::s2dw_qstat_type             qstat,
   output logic                                 push,
   output s2dw_pkg::s2dw_entry_type             push_entry
);

   logic                                    in_range;
   logic                                    neg;
   logic [s2dw_pkg::VALUE_W-1:0]            neg_value;
   logic [s2dw_pkg::MAG_W-1:0]              mag;
   logic [s2dw_pkg::MAG_W+s2dw_pkg::RECIP1000_W-1:0] thou_prod;
   logic [s2dw_pkg::DIGIT_W-1:0]            thou;
   logic [s2dw_pkg::MAG_W-1:0]              thou_scaled;
   logic [s2dw_pkg::MAG_W-1:0]              rem_full;

   // Accept whenever the queue has room; dropped requests are taken without a push
   assign req_tready = !qstat.full;

   // Classify range and sign, take the magnitude
   always_comb begin
      in_range  = (req_value <= s2dw_pkg::UPPER_LIMIT) &&
                  (req_value >= s2dw_pkg::LOWER_LIMIT);
      neg       = req_value[s2dw_pkg::VALUE_W-1];
      neg_value = -req_value;
      mag       = neg ? neg_value[s2dw_pkg::MAG_W-1:0]
                      : req_value[s2dw_pkg::MAG_W-1:0];
   end

   // Split off the thousands digit by reciprocal multiply
   always_comb begin
      thou_prod   = (s2dw_pkg::MAG_W+s2dw_pkg::RECIP1000_W)'(mag) *
                    (s2dw_pkg::MAG_W+s2dw_pkg::RECIP1000_W)'(s2dw_pkg::RECIP1000);
      thou        = thou_prod[s2dw_pkg::RECIP1000_SH +: s2dw_pkg::DIGIT_W];
      thou_scaled = s2dw_pkg::MAG_W'(thou) * s2dw_pkg::MAG_W'(1000);
      rem_full    = mag - thou_scaled;
   end

   assign push            = req_tvalid && req_tready && in_range;
   assign push_entry.neg  = neg;
   assign push_entry.thou = thou;
   assign push_entry.rem  = rem_full[s2dw_pkg::REM_W-1:0];

endmodule

// ----- rtl/s2dw_back.sv -----
// Back end: emits the four digit writes of each queued request, one a cycle while rsp is not stalled.
`timescale 1ns / 1ps

module s2dw_back (
   input  logic                             clock,
   input  logic                             reset,
   input  s2dw_pkg::s2dw_entry_type         head,
   input  s2dw_pkg::s2dw_qstat_type         qstat,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [s2dw_pkg::ADDR_W-1:0]      rsp_addr,
   output logic [s2dw_pkg::DATA_W-1:0]      rsp_data,
   output logic                             rsp_last
);

   logic [s2dw_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [s2dw_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic                         valid_ff, valid_in;
   logic [s2dw_pkg::ADDR_W-1:0]  addr_ff, addr_in;
   logic [s2dw_pkg::DATA_W-1:0]  data_ff, data_in;
   logic                         last_ff, last_in;
   logic                         advance;
   logic [s2dw_pkg::REM_W+s2dw_pkg::RECIP10_W-1:0] quot_prod;
   logic [s2dw_pkg::REM_W-1:0]   quot;
   logic [s2dw_pkg::REM_W-1:0]   digit_full;

   // Output register frees when empty or taken
   assign advance = !valid_ff || rsp_tready;
   assign pop     = advance && (step_ff == s2dw_pkg::STEP_TOP) && !qstat.empty;

   // Peel one decimal digit off the remainder
   always_comb begin
      quot_prod  = (s2dw_pkg::REM_W+s2dw_pkg::RECIP10_W)'(rem_ff) *
                   (s2dw_pkg::REM_W+s2dw_pkg::RECIP10_W)'(s2dw_pkg::RECIP10);
      quot       = s2dw_pkg::REM_W'(quot_prod >> s2dw_pkg::RECIP10_SH);
      digit_full = rem_ff - s2dw_pkg::REM_W'(quot * s2dw_pkg::REM_W'(10));
   end

   // Step through top, units, tens, hundreds
   always_comb begin
      step_in  = step_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff;
      addr_in  = addr_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (advance) begin
         case (step_ff)
            s2dw_pkg::STEP_TOP: begin
               valid_in = !qstat.empty;
               if (!qstat.empty) begin
                  addr_in = s2dw_pkg::ADDR_TOP;
                  data_in = head.neg ? s2dw_pkg::SIGN_CODE
                                     : s2dw_pkg::DATA_W'(head.thou);
                  last_in = 1'b0;
                  rem_in  = head.rem;
                  step_in = s2dw_pkg::STEP_UNITS;
               end
            end
            s2dw_pkg::STEP_UNITS: begin
               valid_in = 1'b1;
               addr_in  = s2dw_pkg::ADDR_UNITS;
               data_in  = s2dw_pkg::DATA_W'(digit_full[s2dw_pkg::DIGIT_W-1:0]);
               last_in  = 1'b0;
               rem_in   = quot;
               step_in  = s2dw_pkg::STEP_TENS;
            end
            s2dw_pkg::STEP_TENS: begin
               valid_in = 1'b1;
               addr_in  = s2dw_pkg::ADDR_TENS;
               data_in  = s2dw_pkg::DATA_W'(digit_full[s2dw_pkg::DIGIT_W-1:0]);
               last_in  = 1'b0;
               rem_in   = quot;
               step_in  = s2dw_pkg::STEP_HUNDREDS;
            end
            s2dw_pkg::STEP_HUNDREDS: begin
               valid_in = 1'b1;
               addr_in  = s2dw_pkg::ADDR_HUNDREDS;
               data_in  = s2dw_pkg::DATA_W'(digit_full[s2dw_pkg::DIGIT_W-1:0]);
               last_in  = 1'b1;
               rem_in   = quot;
               step_in  = s2dw_pkg::STEP_TOP;
            end
            default: begin
               step_in = s2dw_pkg::STEP_TOP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= s2dw_pkg::STEP_TOP;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_addr   = addr_ff;
   assign rsp_data   = data_ff;
   assign rsp_last   = last_ff;

endmodule

// ----- rtl/signed_number_to_digit_writes_core.sv -----
// Top level of the signed number to digit register write core.
//
//   channel | direction | payload
//   req     | in        | tdata[15:0] value (signed)
//   rsp     | out       | tdata[2:0] digit_address, tdata[10:3] digit_data; tlast last_write
//
// An in-range number gives four writes, emitted by the back end one write a cycle while
// rsp is not stalled. Out-of-range numbers are taken and give nothing.
// The front accepts a number each cycle while the two-entry queue has room.
// Reset clears the queue and the output register; a stall on rsp holds the back end
// while the front keeps filling the queue.
`timescale 1ns / 1ps

module signed_number_to_digit_writes_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [s2dw_pkg::VALUE_W-1:0]        req_tdata,   // [15:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [s2dw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [2:0] address, [10:3] data
   output logic                                rsp_tlast
);

   s2dw_pkg::s2dw_entry_type     push_entry;
   s2dw_pkg::s2dw_entry_type     head;
   s2dw_pkg::s2dw_qstat_type     qstat;
   logic                         push;
   logic                         pop;
   logic [s2dw_pkg::ADDR_W-1:0]  rsp_addr;
   logic [s2dw_pkg::DATA_W-1:0]  rsp_data;
   logic                         rsp_last_w;

   s2dw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_value  ($signed(req_tdata)),
      .qstat      (qstat),
      .push       (push),
      .push_entry (push_entry)
   );

   s2dw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (qstat)
   );

   s2dw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_addr   (rsp_addr),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last_w)
   );

   // Pack response fields, zero fill to whole bytes
   assign rsp_tdata = {{(s2dw_pkg::RSP_TDATA_W-s2dw_pkg::DATA_W-s2dw_pkg::ADDR_W){1'b0}},
                       rsp_data, rsp_addr};
   assign rsp_tlast = rsp_last_w;

endmodule

// ----- rtl/s2dw_checker.sv -----
// Port-level checker of the digit write core and its bind.
`timescale 1ns / 1ps
`include "signed_number_to_digit_writes_core_defines.svh"

module s2dw_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [s2dw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   // A stalled response holds its payload
   `S2DW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // The marked write is always the hundreds digit
   `S2DW_ASSERT_NOW(a_last_is_hundreds, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[2:0] == s2dw_pkg::ADDR_HUNDREDS)

   // Lower digits are plain BCD
   `S2DW_ASSERT_NOW(a_lower_bcd, clock, reset, rsp_tvalid && (rsp_tdata[2:0] != s2dw_pkg::ADDR_TOP), rsp_tdata[10:3] <= 8'd9)

   // The top write carries a digit or the sign code
   `S2DW_ASSERT_NOW(a_top_data, clock, reset, rsp_tvalid && (rsp_tdata[2:0] == s2dw_pkg::ADDR_TOP), (rsp_tdata[10:3] <= 8'd9) || (rsp_tdata[10:3] == s2dw_pkg::SIGN_CODE))

endmodule

bind signed_number_to_digit_writes_core s2dw_checker u_s2dw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
